FILE: design/bpdsl_pkg.sv
// ----------------------------------------------------------------------------
// bpdsl_pkg
// Shared types and constants of the brake pipe delay, slew and lag block:
// register indexes, register reset values, sequencer states and defaults
// for the delay line geometry.
// ----------------------------------------------------------------------------
package bpdsl_pkg;

  // Default delay line geometry.
  localparam int DELAY_DEPTH_DEF   = 64;
  localparam int SERVICE_TAP_DEF   = 24;
  localparam int EMERGENCY_TAP_DEF = 8;

  // Field widths.
  localparam int REG_W    = 16;
  localparam int DEMAND_W = 17;
  localparam int CFG_AW   = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Full service demand in Q1.16.
  localparam logic [DEMAND_W-1:0] DEMAND_FULL = 17'h10000;

  // Configuration register indexes.
  typedef enum logic [CFG_AW-1:0] {
    REG_NOMINAL   = 3'd0,
    REG_FSD       = 3'd1,
    REG_GAIN      = 3'd2,
    REG_CAP       = 3'd3,
    REG_APPLY     = 3'd4,
    REG_RELEASE   = 3'd5,
    REG_EMERGENCY = 3'd6,
    REG_ALPHA     = 3'd7
  } cfg_idx_t;

  // Register reset values.
  localparam logic [REG_W-1:0] NOMINAL_RST   = 16'd20480;
  localparam logic [REG_W-1:0] FSD_RST       = 16'd6144;
  localparam logic [REG_W-1:0] GAIN_RST      = 16'd10923;
  localparam logic [REG_W-1:0] CAP_RST       = 16'd24576;
  localparam logic [REG_W-1:0] APPLY_RST     = 16'd41;
  localparam logic [REG_W-1:0] RELEASE_RST   = 16'd20;
  localparam logic [REG_W-1:0] EMERGENCY_RST = 16'd164;
  localparam logic [REG_W-1:0] ALPHA_RST     = 16'd3000;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_PIPE,
    ST_FORCE,
    ST_DIFF,
    ST_LAG
  } state_t;

endpackage

FILE: design/brake_pipe_delay_slew_lag.sv
// ----------------------------------------------------------------------------
// brake_pipe_delay_slew_lag
// Brake pipe model per tick: target drop through a dead-time delay line,
// slew-limited pipe pressure and a first-order lagged cylinder force.
// ----------------------------------------------------------------------------
// One tick is one input transfer and gives one output transfer. The result is
// presented once the sequencer has stepped through a tick, and the input is
// ready again in the same cycle, so a new tick is taken only after the last:
// a single 17x16 multiplier serves the three products of a tick (service
// drop, target force, lag increment) in turn under a five-step sequencer, and
// the delay line is a memory with one write and one registered read per tick.
// The input is taken again as soon as the sequencer is back in idle, even
// while the previous result waits in the output register; the final step of a
// tick waits only while that register is still full and the receiver holds
// off. The delay line reads as zero until written; a fill count tracks this,
// so no clearing pass follows reset. Configuration writes are taken in any
// cycle and should only be issued while no tick is in progress.
module brake_pipe_delay_slew_lag #(
  parameter int DELAY_DEPTH   = bpdsl_pkg::DELAY_DEPTH_DEF,
  parameter int SERVICE_TAP   = bpdsl_pkg::SERVICE_TAP_DEF,
  parameter int EMERGENCY_TAP = bpdsl_pkg::EMERGENCY_TAP_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bpdsl_pkg::IN_TDATA_W-1:0]    in_tdata,   // [16:0] handle_demand
  input  logic                                in_tuser,   // [0] emergency_request
  // Result channel.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bpdsl_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [15:0] pipe_pressure_out,
                                                          // [31:16] cylinder_force_out
  // Configuration write port.
  input  logic                                cfg_wr_en,
  input  logic [bpdsl_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [bpdsl_pkg::REG_W-1:0]         cfg_wdata
);

  localparam int IW      = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int FW      = $clog2(DELAY_DEPTH + 1);
  localparam int SVC_MOD = SERVICE_TAP % DELAY_DEPTH;
  localparam int EMG_MOD = EMERGENCY_TAP % DELAY_DEPTH;
  localparam int SVC_OFF = (SVC_MOD == 0) ? 0 : DELAY_DEPTH - SVC_MOD;
  localparam int EMG_OFF = (EMG_MOD == 0) ? 0 : DELAY_DEPTH - EMG_MOD;
  localparam logic [IW:0]   SVC_OFF_V = (IW+1)'(SVC_OFF);
  localparam logic [IW:0]   EMG_OFF_V = (IW+1)'(EMG_OFF);
  localparam logic [IW:0]   DEPTH_V   = (IW+1)'(DELAY_DEPTH);
  localparam logic [IW-1:0] LAST_IDX  = IW'(DELAY_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX  = FW'(DELAY_DEPTH);

  localparam int RW = bpdsl_pkg::REG_W;
  localparam int DW = bpdsl_pkg::DEMAND_W;

  // Configuration registers.
  logic [RW-1:0] nominal_r, fsd_r, gain_r, cap_r;
  logic [RW-1:0] apply_r, release_r, emergency_r, alpha_r;

  // Sequencer and tick state.
  bpdsl_pkg::state_t state_r, state_nxt;
  logic [DW-1:0]     demand_r;
  logic              emerg_r;
  logic [IW-1:0]     wr_head_r;
  logic [FW-1:0]     fill_r;
  logic [RW-1:0]     drop_r;
  logic              bypass_r;
  logic              rd_valid_r;
  logic [RW-1:0]     rd_data_r;
  logic [RW-1:0]     pipe_r, pipe_nxt;
  logic [RW-1:0]     force_r, force_nxt;
  logic [RW-1:0]     diff_r, diff_nxt;
  logic              rise_r, rise_nxt;
  logic [RW-1:0]     cyl_r, cyl_nxt;

  // Output register.
  logic              out_valid_r;
  logic [RW-1:0]     out_pipe_r, out_cyl_r;

  // Delay line memory.
  logic [RW-1:0] delay_mem [DELAY_DEPTH];

  // Control decoded from the state.
  logic          accept;
  logic          mem_step;
  logic          pipe_step;
  logic          force_step;
  logic          diff_step;
  logic          lag_step;
  logic          out_free;

  // Shared multiplier.
  logic [DW-1:0]    mul_a;
  logic [RW-1:0]    mul_b;
  logic [DW+RW-1:0] mul_p;

  // Delay line addressing.
  logic [IW:0]   rd_sum;
  logic [IW-1:0] rd_idx;
  logic [RW-1:0] drop_nxt;
  logic [RW-1:0] delayed;

  // Pipe slew arithmetic.
  logic signed [18:0] target_p, pipe_s, delta, step_s, new_p, nom_s;
  logic               apply_dir;

  // Force and lag arithmetic.
  logic [19:0]   force_raw;
  logic [RW-1:0] lag_adj;

  assign out_free = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpdsl_pkg::ST_IDLE:  if (in_tvalid) state_nxt = bpdsl_pkg::ST_DROP;
      bpdsl_pkg::ST_DROP:  state_nxt = bpdsl_pkg::ST_PIPE;
      bpdsl_pkg::ST_PIPE:  state_nxt = bpdsl_pkg::ST_FORCE;
      bpdsl_pkg::ST_FORCE: state_nxt = bpdsl_pkg::ST_DIFF;
      bpdsl_pkg::ST_DIFF:  state_nxt = bpdsl_pkg::ST_LAG;
      bpdsl_pkg::ST_LAG:   if (out_free) state_nxt = bpdsl_pkg::ST_IDLE;
      default:             state_nxt = bpdsl_pkg::ST_IDLE;
    endcase
  end

  // Control outputs and multiplier operand selection.
  always_comb begin
    in_tready  = 1'b0;
    mem_step   = 1'b0;
    pipe_step  = 1'b0;
    force_step = 1'b0;
    diff_step  = 1'b0;
    lag_step   = 1'b0;
    mul_a      = demand_r;
    mul_b      = fsd_r;
    case (state_r)
      bpdsl_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      bpdsl_pkg::ST_DROP: begin
        mem_step = 1'b1;
        mul_a    = demand_r;
        mul_b    = fsd_r;
      end
      bpdsl_pkg::ST_PIPE: begin
        pipe_step = 1'b1;
      end
      bpdsl_pkg::ST_FORCE: begin
        force_step = 1'b1;
        mul_a      = {1'b0, nominal_r - pipe_r};
        mul_b      = gain_r;
      end
      bpdsl_pkg::ST_DIFF: begin
        diff_step = 1'b1;
      end
      bpdsl_pkg::ST_LAG: begin
        lag_step = out_free;
        mul_a    = {1'b0, diff_r};
        mul_b    = alpha_r;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign accept = in_tvalid && in_tready;
  assign mul_p  = mul_a * mul_b;

  // Target drop and delay line read address.
  always_comb begin
    drop_nxt = emerg_r ? nominal_r : mul_p[31:16];
    rd_sum   = {1'b0, wr_head_r} + (emerg_r ? EMG_OFF_V : SVC_OFF_V);
    if (rd_sum >= DEPTH_V) begin
      rd_sum = rd_sum - DEPTH_V;
    end
    rd_idx = rd_sum[IW-1:0];
  end

  // Delayed drop: same-tick value for a zero tap, zero for unwritten entries.
  always_comb begin
    if (bypass_r) begin
      delayed = drop_r;
    end else if (rd_valid_r) begin
      delayed = rd_data_r;
    end else begin
      delayed = '0;
    end
  end

  // Slew-limited pipe pressure, clamped to 0..nominal.
  always_comb begin
    nom_s     = signed'({3'b000, nominal_r});
    pipe_s    = signed'({3'b000, pipe_r});
    target_p  = nom_s - signed'({3'b000, delayed});
    apply_dir = target_p < pipe_s;
    if (emerg_r) begin
      step_s = signed'({3'b000, emergency_r});
    end else if (apply_dir) begin
      step_s = signed'({3'b000, apply_r});
    end else begin
      step_s = signed'({3'b000, release_r});
    end
    delta = target_p - pipe_s;
    if (delta > step_s) begin
      delta = step_s;
    end
    if (delta < -step_s) begin
      delta = -step_s;
    end
    new_p = pipe_s + delta;
    if (new_p > nom_s) begin
      new_p = nom_s;
    end
    if (new_p < 19'sd0) begin
      new_p = 19'sd0;
    end
    pipe_nxt = new_p[RW-1:0];
  end

  // Capped target force, then the lag difference and direction.
  always_comb begin
    force_raw = mul_p[31:12];
    force_nxt = (force_raw > {4'h0, cap_r}) ? cap_r : force_raw[RW-1:0];
    rise_nxt  = force_r >= cyl_r;
    diff_nxt  = rise_nxt ? (force_r - cyl_r) : (cyl_r - force_r);
    lag_adj   = mul_p[31:16];
    cyl_nxt   = rise_r ? (cyl_r + lag_adj) : (cyl_r - lag_adj);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_r   <= bpdsl_pkg::NOMINAL_RST;
      fsd_r       <= bpdsl_pkg::FSD_RST;
      gain_r      <= bpdsl_pkg::GAIN_RST;
      cap_r       <= bpdsl_pkg::CAP_RST;
      apply_r     <= bpdsl_pkg::APPLY_RST;
      release_r   <= bpdsl_pkg::RELEASE_RST;
      emergency_r <= bpdsl_pkg::EMERGENCY_RST;
      alpha_r     <= bpdsl_pkg::ALPHA_RST;
    end else if (cfg_wr_en) begin
      case (bpdsl_pkg::cfg_idx_t'(cfg_addr))
        bpdsl_pkg::REG_NOMINAL:   nominal_r   <= cfg_wdata;
        bpdsl_pkg::REG_FSD:       fsd_r       <= cfg_wdata;
        bpdsl_pkg::REG_GAIN:      gain_r      <= cfg_wdata;
        bpdsl_pkg::REG_CAP:       cap_r       <= cfg_wdata;
        bpdsl_pkg::REG_APPLY:     apply_r     <= cfg_wdata;
        bpdsl_pkg::REG_RELEASE:   release_r   <= cfg_wdata;
        bpdsl_pkg::REG_EMERGENCY: emergency_r <= cfg_wdata;
        bpdsl_pkg::REG_ALPHA:     alpha_r     <= cfg_wdata;
        default:                  nominal_r   <= nominal_r;
      endcase
    end
  end

  // Sequencer and tick state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bpdsl_pkg::ST_IDLE;
      wr_head_r <= '0;
      fill_r    <= '0;
      pipe_r    <= bpdsl_pkg::NOMINAL_RST;
      cyl_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (mem_step) begin
        wr_head_r <= (wr_head_r == LAST_IDX) ? '0 : wr_head_r + 1'b1;
        if (fill_r != FILL_MAX) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (pipe_step) begin
        pipe_r <= pipe_nxt;
      end
      if (lag_step) begin
        cyl_r <= cyl_nxt;
      end
    end
  end

  // Tick payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      demand_r <= (in_tdata[DW-1:0] > bpdsl_pkg::DEMAND_FULL) ?
                  bpdsl_pkg::DEMAND_FULL : in_tdata[DW-1:0];
      emerg_r  <= in_tuser;
    end
    if (mem_step) begin
      drop_r     <= drop_nxt;
      bypass_r   <= (rd_idx == wr_head_r);
      rd_valid_r <= (FW'(rd_idx) < fill_r) || (rd_idx == wr_head_r);
    end
    if (force_step) begin
      force_r <= force_nxt;
    end
    if (diff_step) begin
      diff_r <= diff_nxt;
      rise_r <= rise_nxt;
    end
  end

  // Delay line memory: one write and one registered read per tick.
  always_ff @(posedge clk) begin
    if (mem_step) begin
      delay_mem[wr_head_r] <= drop_nxt;
      rd_data_r            <= delay_mem[rd_idx];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (lag_step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lag_step) begin
      out_pipe_r <= pipe_r;
      out_cyl_r  <= cyl_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cyl_r, out_pipe_r};

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the brake pipe delay, slew and lag block. A table
// of directed ticks and then shaped random braking sequences (service holds,
// releases, emergency runs and noise) are sent under several register
// settings. A built-in predictor tracks the delay line, pipe pressure and
// cylinder force, and every result transfer is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_TAIL  = 16;

  typedef logic [bpdsl_pkg::REG_W-1:0] reg_set_t [8];

  // Result layout as it travels in out_tdata, force in the upper half.
  typedef struct packed {
    logic [15:0] cyl_force;
    logic [15:0] pipe;
  } brake_out_t;

  typedef struct packed {
    logic [bpdsl_pkg::DEMAND_W-1:0] dem;
    logic                           emg;
    logic                           known;
    logic [15:0]                    pipe;
    logic [15:0]                    cyl_force;
  } tick_row_t;

  typedef enum int {SEG_APPLY, SEG_RELEASE, SEG_EMERG, SEG_NOISE} seg_kind_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [bpdsl_pkg::IN_TDATA_W-1:0]  in_tdata;   // [16:0] handle_demand
  logic                              in_tuser;   // [0] emergency_request
  logic                              out_tvalid;
  logic                              out_tready;
  logic [bpdsl_pkg::OUT_TDATA_W-1:0] out_tdata;  // [15:0] pipe_pressure_out,
                                                 // [31:16] cylinder_force_out
  logic                              cfg_wr_en;
  bpdsl_pkg::cfg_idx_t               cfg_addr;
  logic [bpdsl_pkg::REG_W-1:0]       cfg_wdata;

  brake_pipe_delay_slew_lag u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Predictor state: registers, delay line, write pointer, pipe and force.
  logic [bpdsl_pkg::REG_W-1:0] shadow_regs [8];
  logic [15:0]                 drop_line [bpdsl_pkg::DELAY_DEPTH_DEF];
  int                          wr_head;
  logic [15:0]                 pipe_state;
  logic [15:0]                 force_state;

  brake_out_t pending_ticks [$];
  int         mismatch_count;
  int         results_checked;
  int         ticks_sent;
  int         emerg_ticks;
  int         settings_used;
  int         cyc_count;
  bit         tx_idle_on;
  bit         rx_stall_on;
  bit         rx_long_hold;
  bit         valid_up;

  // Directed ticks. The first rows read only zeros from the delay line, so
  // the pipe stays at nominal and the force at zero.
  localparam int DIR_ROWS = 20;
  tick_row_t dir_rows [DIR_ROWS] = '{
    '{17'h00000, 1'b0, 1'b1, 16'd20480, 16'd0},
    '{17'h10000, 1'b0, 1'b1, 16'd20480, 16'd0},
    '{17'h1FFFF, 1'b0, 1'b1, 16'd20480, 16'd0},
    '{17'h00000, 1'b1, 1'b1, 16'd20480, 16'd0},
    '{17'h0AAAA, 1'b1, 1'b0, 16'd0, 16'd0},
    '{17'h15555, 1'b1, 1'b0, 16'd0, 16'd0},
    '{17'h10000, 1'b1, 1'b0, 16'd0, 16'd0},
    '{17'h1FFFF, 1'b1, 1'b0, 16'd0, 16'd0},
    '{17'h00000, 1'b1, 1'b0, 16'd0, 16'd0},
    '{17'h00001, 1'b1, 1'b0, 16'd0, 16'd0},
    '{17'h0FFFF, 1'b1, 1'b0, 16'd0, 16'd0},
    '{17'h08000, 1'b1, 1'b0, 16'd0, 16'd0},
    '{17'h00000, 1'b1, 1'b0, 16'd0, 16'd0},
    '{17'h00000, 1'b1, 1'b0, 16'd0, 16'd0},
    '{17'h0FFFF, 1'b0, 1'b0, 16'd0, 16'd0},
    '{17'h10001, 1'b0, 1'b0, 16'd0, 16'd0},
    '{17'h08000, 1'b0, 1'b0, 16'd0, 16'd0},
    '{17'h00001, 1'b0, 1'b0, 16'd0, 16'd0},
    '{17'h15555, 1'b0, 1'b0, 16'd0, 16'd0},
    '{17'h00000, 1'b0, 1'b0, 16'd0, 16'd0}
  };

  // Clock with a 4 ns period.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Computes one tick of the brake pipe and advances the predictor state.
  function automatic brake_out_t advance_brake_tick(
      input logic [bpdsl_pkg::DEMAND_W-1:0] dem, input logic emg);
    logic [bpdsl_pkg::DEMAND_W-1:0] dem_sat;
    logic [15:0]         drop_tgt;
    logic [15:0]         delayed;
    longint unsigned     wide;
    longint unsigned     tgt_force;
    longint unsigned     cur;
    int                  tap;
    int                  rd;
    int                  nominal;
    int                  pipe;
    int                  tgt_p;
    int                  delta;
    int                  step;
    brake_out_t          res;
    dem_sat = (dem > bpdsl_pkg::DEMAND_FULL) ? bpdsl_pkg::DEMAND_FULL : dem;
    nominal = int'(shadow_regs[bpdsl_pkg::REG_NOMINAL]);

    // Target drop goes into the delay line, then the tap is read back.
    if (emg) begin
      drop_tgt = shadow_regs[bpdsl_pkg::REG_NOMINAL];
    end else begin
      wide = dem_sat;
      wide = (wide * shadow_regs[bpdsl_pkg::REG_FSD]) >> 16;
      drop_tgt = wide[15:0];
    end
    drop_line[wr_head] = drop_tgt;
    tap = (emg ? bpdsl_pkg::EMERGENCY_TAP_DEF : bpdsl_pkg::SERVICE_TAP_DEF) %
          bpdsl_pkg::DELAY_DEPTH_DEF;
    rd = (wr_head + bpdsl_pkg::DELAY_DEPTH_DEF - tap) % bpdsl_pkg::DELAY_DEPTH_DEF;
    delayed = drop_line[rd];
    wr_head = (wr_head + 1) % bpdsl_pkg::DELAY_DEPTH_DEF;

    // Slew toward nominal minus the delayed drop, then clamp.
    pipe = int'(pipe_state);
    tgt_p = nominal - int'(delayed);
    if (emg) begin
      step = int'(shadow_regs[bpdsl_pkg::REG_EMERGENCY]);
    end else if (tgt_p < pipe) begin
      step = int'(shadow_regs[bpdsl_pkg::REG_APPLY]);
    end else begin
      step = int'(shadow_regs[bpdsl_pkg::REG_RELEASE]);
    end
    delta = tgt_p - pipe;
    if (delta > step) delta = step;
    if (delta < -step) delta = -step;
    pipe = pipe + delta;
    if (pipe > nominal) pipe = nominal;
    if (pipe < 0) pipe = 0;
    pipe_state = 16'(pipe);

    // Target force from the pipe drop, capped.
    wide = nominal - pipe;
    tgt_force = (wide * shadow_regs[bpdsl_pkg::REG_GAIN]) >> 12;
    if (tgt_force > shadow_regs[bpdsl_pkg::REG_CAP]) begin
      tgt_force = shadow_regs[bpdsl_pkg::REG_CAP];
    end

    // First-order lag with the increment truncated toward the old force.
    cur = force_state;
    if (tgt_force >= cur) begin
      wide = ((tgt_force - cur) * shadow_regs[bpdsl_pkg::REG_ALPHA]) >> 16;
      force_state = 16'(cur + wide);
    end else begin
      wide = ((cur - tgt_force) * shadow_regs[bpdsl_pkg::REG_ALPHA]) >> 16;
      force_state = 16'(cur - wide);
    end

    res.pipe = pipe_state;
    res.cyl_force = force_state;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Offers one tick and waits for its transfer; valid stays up afterwards.
  task automatic send_tick(input logic [bpdsl_pkg::DEMAND_W-1:0] dem, input logic emg,
                           input bit known, input brake_out_t known_res);
    brake_out_t res;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(bpdsl_pkg::IN_TDATA_W-bpdsl_pkg::DEMAND_W){1'b0}}, dem};
    in_tuser  <= emg;
    valid_up = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = advance_brake_tick(dem, emg);
    pending_ticks.push_back(known ? known_res : res);
    ticks_sent++;
    if (emg) emerg_ticks++;
  endtask

  task automatic drop_valid();
    if (valid_up) begin
      in_tvalid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // Sender idles now and then for a random burst.
  task automatic tx_gap();
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      drop_valid();
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Sender pauses until every pending result has come back.
  task automatic wait_idle();
    drop_valid();
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes all eight registers back to back; only called while idle.
  task automatic load_config(input reg_set_t vals);
    bpdsl_pkg::cfg_idx_t idx;
    idx = idx.first();
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= idx;
      cfg_wdata <= vals[i];
      shadow_regs[idx] = vals[i];
      @(posedge clk);
      idx = idx.next();
    end
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic reg_set_t random_config();
    reg_set_t vals;
    vals[bpdsl_pkg::REG_NOMINAL]   = 16'($urandom_range(1024, 65535));
    vals[bpdsl_pkg::REG_FSD]       = 16'($urandom_range(1, 65535));
    vals[bpdsl_pkg::REG_GAIN]      = 16'($urandom_range(0, 65535));
    vals[bpdsl_pkg::REG_CAP]       = 16'($urandom_range(0, 65535));
    vals[bpdsl_pkg::REG_APPLY]     = 16'($urandom_range(0, 3) == 0 ?
                                         $urandom_range(0, 65535) :
                                         $urandom_range(1, 2000));
    vals[bpdsl_pkg::REG_RELEASE]   = 16'($urandom_range(0, 3) == 0 ?
                                         $urandom_range(0, 65535) :
                                         $urandom_range(1, 2000));
    vals[bpdsl_pkg::REG_EMERGENCY] = 16'($urandom_range(0, 3) == 0 ?
                                         $urandom_range(0, 65535) :
                                         $urandom_range(1, 4000));
    vals[bpdsl_pkg::REG_ALPHA]     = 16'($urandom_range(0, 65535));
    return vals;
  endfunction

  // Random braking sequences: service holds, releases, emergency runs, noise.
  task automatic run_stimulus(input int n_items);
    int          sent;
    int          seg_len;
    int          pick;
    seg_kind_t   kind;
    logic [bpdsl_pkg::DEMAND_W-1:0] dem;
    logic        emg;
    brake_out_t  unused_res;
    sent = 0;
    unused_res = '0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 4) ? SEG_APPLY : (pick < 6) ? SEG_RELEASE :
             (pick < 8) ? SEG_EMERG : SEG_NOISE;
      seg_len = $urandom_range(1, 30);
      dem = ($urandom_range(0, 4) == 0) ? bpdsl_pkg::DEMAND_FULL :
            bpdsl_pkg::DEMAND_W'($urandom_range(0, 65536));
      for (int k = 0; k < seg_len && sent < n_items; k++) begin
        case (kind)
          SEG_APPLY: begin
            emg = 1'b0;
          end
          SEG_RELEASE: begin
            dem = '0;
            emg = 1'b0;
          end
          SEG_EMERG: begin
            dem = bpdsl_pkg::DEMAND_W'($urandom_range(0, 17'h1FFFF));
            emg = 1'b1;
          end
          default: begin
            dem = bpdsl_pkg::DEMAND_W'($urandom_range(0, 17'h1FFFF));
            emg = 1'($urandom_range(0, 1));
          end
        endcase
        send_tick(dem, emg, 1'b0, unused_res);
        tx_gap();
        sent++;
      end
    end
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin : receiver
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rx_long_hold = 1'b0;
      end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Checks each result transfer against the oldest pending tick.
  always @(posedge clk) begin
    brake_out_t got;
    brake_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_ticks.size() == 0) begin
        report_mismatch($sformatf("result with no tick pending: pipe %0d force %0d",
                                  got.pipe, got.cyl_force));
      end else begin
        want = pending_ticks.pop_front();
        results_checked++;
        if (got.pipe !== want.pipe)
          report_mismatch($sformatf("result %0d pipe_pressure_out got %0d want %0d",
                                    results_checked, got.pipe, want.pipe));
        if (got.cyl_force !== want.cyl_force)
          report_mismatch($sformatf("result %0d cylinder_force_out got %0d want %0d",
                                    results_checked, got.cyl_force, want.cyl_force));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cyc_count,
               pending_ticks.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : main
    reg_set_t vals;
    brake_out_t known_res;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr = bpdsl_pkg::REG_NOMINAL;
    cfg_wdata = '0;
    cyc_count = 0;
    mismatch_count = 0;
    results_checked = 0;
    ticks_sent = 0;
    emerg_ticks = 0;
    settings_used = 1;
    tx_idle_on = 1'b1;
    rx_stall_on = 1'b1;
    rx_long_hold = 1'b0;
    valid_up = 1'b0;

    // Predictor reset.
    shadow_regs[bpdsl_pkg::REG_NOMINAL]   = bpdsl_pkg::NOMINAL_RST;
    shadow_regs[bpdsl_pkg::REG_FSD]       = bpdsl_pkg::FSD_RST;
    shadow_regs[bpdsl_pkg::REG_GAIN]      = bpdsl_pkg::GAIN_RST;
    shadow_regs[bpdsl_pkg::REG_CAP]       = bpdsl_pkg::CAP_RST;
    shadow_regs[bpdsl_pkg::REG_APPLY]     = bpdsl_pkg::APPLY_RST;
    shadow_regs[bpdsl_pkg::REG_RELEASE]   = bpdsl_pkg::RELEASE_RST;
    shadow_regs[bpdsl_pkg::REG_EMERGENCY] = bpdsl_pkg::EMERGENCY_RST;
    shadow_regs[bpdsl_pkg::REG_ALPHA]     = bpdsl_pkg::ALPHA_RST;
    foreach (drop_line[i]) drop_line[i] = '0;
    wr_head = 0;
    pipe_state = bpdsl_pkg::NOMINAL_RST;
    force_state = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset register values.
    foreach (dir_rows[i]) begin
      known_res.pipe = dir_rows[i].pipe;
      known_res.cyl_force = dir_rows[i].cyl_force;
      send_tick(dir_rows[i].dem, dir_rows[i].emg, dir_rows[i].known, known_res);
      tx_gap();
    end

    // All registers at their top value; the receiver holds off at the start
    // so the block backs up and stalls its input.
    wait_idle();
    foreach (vals[i]) vals[i] = 16'hFFFF;
    load_config(vals);
    rx_long_hold = 1'b1;
    run_stimulus(60);

    // Nominal lowered below the current pipe pressure, and drops far beyond
    // nominal so the target pressure goes negative.
    wait_idle();
    vals[bpdsl_pkg::REG_NOMINAL]   = 16'd4096;
    vals[bpdsl_pkg::REG_FSD]       = 16'hFFFF;
    vals[bpdsl_pkg::REG_GAIN]      = 16'hFFFF;
    vals[bpdsl_pkg::REG_CAP]       = 16'hFFFF;
    vals[bpdsl_pkg::REG_APPLY]     = 16'd300;
    vals[bpdsl_pkg::REG_RELEASE]   = 16'd200;
    vals[bpdsl_pkg::REG_EMERGENCY] = 16'd500;
    vals[bpdsl_pkg::REG_ALPHA]     = 16'd40000;
    load_config(vals);
    run_stimulus(50);

    // All registers at their bottom value, but FSD, which is set to one.
    wait_idle();
    foreach (vals[i]) vals[i] = 16'h0000;
    vals[bpdsl_pkg::REG_FSD] = 16'd1;
    load_config(vals);
    run_stimulus(30);

    // Random settings; the sender pauses once for a full drain mid-phase.
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      load_config(random_config());
      run_stimulus(40);
      if (p == 0) wait_idle();
      run_stimulus(35);
    end

    // Closing part at the reset values, with no idling on either side.
    wait_idle();
    vals[bpdsl_pkg::REG_NOMINAL]   = bpdsl_pkg::NOMINAL_RST;
    vals[bpdsl_pkg::REG_FSD]       = bpdsl_pkg::FSD_RST;
    vals[bpdsl_pkg::REG_GAIN]      = bpdsl_pkg::GAIN_RST;
    vals[bpdsl_pkg::REG_CAP]       = bpdsl_pkg::CAP_RST;
    vals[bpdsl_pkg::REG_APPLY]     = bpdsl_pkg::APPLY_RST;
    vals[bpdsl_pkg::REG_RELEASE]   = bpdsl_pkg::RELEASE_RST;
    vals[bpdsl_pkg::REG_EMERGENCY] = bpdsl_pkg::EMERGENCY_RST;
    vals[bpdsl_pkg::REG_ALPHA]     = bpdsl_pkg::ALPHA_RST;
    load_config(vals);
    tx_idle_on = 1'b0;
    rx_stall_on = 1'b0;
    run_stimulus(60);

    // Drain and let the pipeline settle.
    drop_valid();
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Sent %0d ticks (%0d emergency) under %0d register settings.",
             ticks_sent, emerg_ticks, settings_used);
    $display("Compared %0d results, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
